[hdl/mi3_pkg.sv]
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared widths, types and cofactor index table for the 3x3 matrix inverse.
// ----------------------------------------------------------------------------
package mi3_pkg;

  localparam int ELEM_W = 32;
  localparam int N_ELEM = 9;
  localparam int PROD_W = 64;
  localparam int ADJ_W  = 65;
  localparam int DET_W  = 97;
  localparam int DMAG_W = 96;
  localparam int QB     = 33;
  localparam int DIV_W  = DMAG_W + QB + 1;

  typedef logic [N_ELEM-1:0][ELEM_W-1:0] mat_t;
  typedef logic [N_ELEM-1:0][ADJ_W-1:0]  adj_t;
  typedef logic [N_ELEM-1:0][DIV_W-1:0]  num_t;

  typedef struct packed {
    logic              zero;
    logic [N_ELEM-1:0] neg;
    logic [DMAG_W-1:0] dmag;
  } div_ctl_t;

  // adj[k] = a[i0]*a[i1] - a[i2]*a[i3]
  localparam logic [3:0] ADJ_IDX [N_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

endpackage

[hdl/matrix_inverse_3x3.sv]
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Inverse of a 3x3 signed fixed-point matrix by adjugate over determinant.
// ----------------------------------------------------------------------------
// One matrix per beat on the slave side: s_tdata carries the nine elements
// row by row, 32 bits each, element r0c0 in the lowest bits. One result per
// beat on the master side: m_tdata carries the nine inverse elements in the
// same order, m_tuser carries singular (bit 0) and overflow (bit 1).
// The pipeline has 2 cofactor stages, 4 determinant stages, one range
// check, 33 restoring divide stages (one quotient bit each) and the output
// register. Throughput is one matrix per cycle while the output is not stalled.
// All stages advance together on one enable; when m_tvalid is high and
// m_tready low the whole pipeline holds and s_tready drops, so no beat is
// lost or repeated. Reset clears every valid bit; data registers are not
// reset. A singular matrix gives all-zero elements with singular set.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3
  import mi3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,  // a_r0c0, a_r0c1, a_r0c2, a_r1c0 .. a_r2c2
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [287:0] m_tdata,  // inv_r0c0, inv_r0c1, inv_r0c2 .. inv_r2c2
  output logic [1:0]   m_tuser   // singular, overflow
);

  logic                          en;
  logic                          cof_valid;
  adj_t                          adj;
  logic [2:0][ELEM_W-1:0]        a_row;
  logic                          det_valid;
  div_ctl_t                      ctl;
  num_t                          num;
  logic [N_ELEM-1:0][ELEM_W-1:0] inv;
  logic                          singular;
  logic                          overflow;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  mi3_cofactor u_cof (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .a         (mat_t'(s_tdata)),
    .out_valid (cof_valid),
    .adj       (adj),
    .a_row     (a_row)
  );

  mi3_det #(.FRAC_BITS(FRAC_BITS)) u_det (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (cof_valid),
    .adj       (adj),
    .a_row     (a_row),
    .out_valid (det_valid),
    .ctl       (ctl),
    .num       (num)
  );

  mi3_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (det_valid),
    .ctl       (ctl),
    .num       (num),
    .out_valid (m_tvalid),
    .inv       (inv),
    .singular  (singular),
    .overflow  (overflow)
  );

  assign m_tdata = inv;
  assign m_tuser = {overflow, singular};

  a_sing_no_ovf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("singular and overflow together");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata == '0)
    else $error("singular result not zero");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("valid result right after reset");

endmodule

[hdl/mi3_cofactor.sv]
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: element products, then the nine adjugate differences.
// ----------------------------------------------------------------------------
module mi3_cofactor
  import mi3_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  mat_t                  a,
  output logic                  out_valid,
  output adj_t                  adj,
  output logic [2:0][ELEM_W-1:0] a_row
);

  logic signed [PROD_W-1:0] p [N_ELEM];
  logic signed [PROD_W-1:0] q [N_ELEM];
  logic [2:0][ELEM_W-1:0]   row1;
  logic                     v1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < N_ELEM; k++) begin
        p[k]   <= $signed(a[ADJ_IDX[k][0]]) * $signed(a[ADJ_IDX[k][1]]);
        q[k]   <= $signed(a[ADJ_IDX[k][2]]) * $signed(a[ADJ_IDX[k][3]]);
        adj[k] <= ADJ_W'(p[k]) - ADJ_W'(q[k]);
      end
      row1  <= a[2:0];
      a_row <= row1;
    end
  end

endmodule

[hdl/mi3_det.sv]
// ----------------------------------------------------------------------------
// mi3_det
// Four stages: split products, recombine, determinant sum, magnitudes and
// shifted numerators.
// ----------------------------------------------------------------------------
module mi3_det
  import mi3_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  adj_t                   adj,
  input  logic [2:0][ELEM_W-1:0] a_row,
  output logic                   out_valid,
  output div_ctl_t               ctl,
  output num_t                   num
);

  logic signed [ADJ_W-1:0] lo [3];
  logic signed [ADJ_W-1:0] hi [3];
  logic signed [DET_W-1:0] prod [3];
  logic signed [DET_W-1:0] det;
  logic signed [DET_W-1:0] det_abs;
  adj_t                    adj3, adj4, adj5;
  logic [2:0]              v;
  logic [ADJ_W-1:0]        mag [N_ELEM];

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v         <= {v[1:0], in_valid};
      out_valid <= v[2];
    end
  end

  always_comb begin
    det_abs = det[DET_W-1] ? -det : det;
    for (int k = 0; k < N_ELEM; k++) begin
      mag[k] = adj5[k][ADJ_W-1] ? -adj5[k] : adj5[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        lo[j]   <= $signed(a_row[j]) * $signed({1'b0, adj[j*3][31:0]});
        hi[j]   <= $signed(a_row[j]) * $signed(adj[j*3][ADJ_W-1:32]);
        prod[j] <= $signed({hi[j], 32'b0}) + $signed({{32{lo[j][ADJ_W-1]}}, lo[j]});
      end
      adj3 <= adj;
      adj4 <= adj3;
      adj5 <= adj4;
      det  <= prod[0] + prod[1] + prod[2];
      ctl.zero <= (det == '0);
      ctl.dmag <= det_abs[DMAG_W-1:0];
      for (int k = 0; k < N_ELEM; k++) begin
        ctl.neg[k] <= adj5[k][ADJ_W-1] ^ det[DET_W-1];
        num[k]     <= DIV_W'(mag[k][ADJ_W-2:0]) << (2 * FRAC_BITS);
      end
    end
  end

endmodule

[hdl/mi3_divider.sv]
// ----------------------------------------------------------------------------
// mi3_divider
// Nine restoring dividers, one quotient bit per stage, range check up front
// and saturation in the output register.
// ----------------------------------------------------------------------------
module mi3_divider
  import mi3_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  div_ctl_t                      ctl,
  input  num_t                          num,
  output logic                          out_valid,
  output logic [N_ELEM-1:0][ELEM_W-1:0] inv,
  output logic                          singular,
  output logic                          overflow
);

  logic [DIV_W-1:0]  rem  [QB+1][N_ELEM];
  logic [QB-1:0]     quo  [QB+1][N_ELEM];
  logic [N_ELEM-1:0] big  [QB+1];
  div_ctl_t          sctl [QB+1];
  logic [QB:0]       sv;

  logic [N_ELEM-1:0]             sat;
  logic [N_ELEM-1:0][ELEM_W-1:0] val;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv        <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      sv        <= {sv[QB-1:0], in_valid};
      out_valid <= sv[QB];
    end
  end

  // range check: quotient of 2^QB or more saturates anyway
  always_ff @(posedge clk) begin
    if (en) begin
      sctl[0] <= ctl;
      for (int l = 0; l < N_ELEM; l++) begin
        rem[0][l] <= num[l];
        quo[0][l] <= '0;
        big[0][l] <= num[l] >= (DIV_W'(ctl.dmag) << QB);
      end
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_step
    localparam int B = QB - s;
    logic [DIV_W-1:0] dsh;
    assign dsh = DIV_W'(sctl[s-1].dmag) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        sctl[s] <= sctl[s-1];
        big[s]  <= big[s-1];
        for (int l = 0; l < N_ELEM; l++) begin
          if (rem[s-1][l] >= dsh) begin
            rem[s][l] <= rem[s-1][l] - dsh;
            quo[s][l] <= quo[s-1][l] | (QB'(1) << B);
          end else begin
            rem[s][l] <= rem[s-1][l];
            quo[s][l] <= quo[s-1][l];
          end
        end
      end
    end
  end

  always_comb begin
    for (int l = 0; l < N_ELEM; l++) begin
      if (!sctl[QB].neg[l]) begin
        sat[l] = big[QB][l] || (quo[QB][l][QB-1:ELEM_W-1] != '0);
        val[l] = sat[l] ? {1'b0, {(ELEM_W-1){1'b1}}} : quo[QB][l][ELEM_W-1:0];
      end else begin
        sat[l] = big[QB][l] || (quo[QB][l] > {2'b01, {(ELEM_W-1){1'b0}}});
        val[l] = sat[l] ? {1'b1, {(ELEM_W-1){1'b0}}} : -quo[QB][l][ELEM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      singular <= sctl[QB].zero;
      overflow <= !sctl[QB].zero && (|sat);
      inv      <= sctl[QB].zero ? '0 : val;
    end
  end

endmodule
